// ===== hdl/bta_pkg.sv =====
// Shared types, codes and helper functions of the buddy tree page allocator.
// No dependencies; used by every module of the block except bta_ram.
`default_nettype none

package bta_pkg;

   // Default number of pages the tree can span
   localparam int unsigned BTA_PAGE_CAP = 1024;

   // Command opcodes
   localparam logic [1:0] OP_BUILD = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // Result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_NOSPACE  = 2'd1;
   localparam logic [1:0] STS_NOTALLOC = 2'd2;
   localparam logic [1:0] STS_BADREQ   = 2'd3;

   // Controller to datapath commands
   typedef struct packed {
      logic       load_req;     // latch the request word
      logic       start_sweep;  // set up a rebuild
      logic       sweep_step;   // write one node of the rebuild
      logic       rd_root;      // read the root, start alloc descent
      logic       rd_leaf;      // read the leaf of the freed page
      logic       desc_rd;      // read left child during descent
      logic       desc_take;    // pick the child from read data
      logic       alloc_found;  // zero the chosen node
      logic       free_up;      // step to the parent, read it
      logic       free_found;   // restore the zeroed node
      logic       climb_rd;     // read the sibling
      logic       climb_wr;     // write the parent
      logic       set_err;      // record an error result
      logic [1:0] err_code;
      logic       emit;         // load the response register
   } bta_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] op;
      logic       managed_zero;
      logic       alloc_bad;
      logic       free_bad;
      logic       root_short;
      logic       desc_more;
      logic       out_range;
      logic       sweep_last;
      logic       node_zero;
      logic       idx_root;
      logic       par_root;
      logic       rsp_busy;
   } bta_sts_type;

   // Highest set bit of v as a one-hot value, zero for zero
   function automatic logic [31:0] bta_hibit(input logic [31:0] v);
      logic [31:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) r = 32'(1) << i;
      end
      return r;
   endfunction

   // Smallest power of two not below v (1 for 0 and 1)
   function automatic logic [31:0] bta_ceil_pow2(input logic [31:0] v);
      logic [31:0] r;
      if (v <= 32'd1) r = 32'd1;
      else            r = bta_hibit(v - 32'd1) << 1;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/buddy_tree_page_allocator.sv =====
// Top level of the buddy tree page allocator: controller plus datapath.
// Depends on bta_pkg, bta_ctrl, bta_dpath (and bta_ram below it).
//
//  channel  | ports                                  | direction
//  req      | req_valid/ready, opcode, pages, offset | in
//  rsp      | rsp_valid/ready, status, offset, pages | out
//  csr      | csr_we, csr_managed_pages              | in
//
// A rebuild writes one node of the tree per cycle. After reset the tree is filled for
// PAGE_CAP pages, with req_ready low and no response. A new word is accepted while a
// finished response still waits; the next response stalls until that one is taken.
`default_nettype none

module buddy_tree_page_allocator
   import bta_pkg::*;
#(
   parameter int unsigned PAGE_CAP = BTA_PAGE_CAP,
   parameter int unsigned PW       = $clog2(PAGE_CAP) + 1,
   parameter int unsigned OW       = $clog2(PAGE_CAP)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [1:0]    req_opcode,
   input  wire logic [PW-1:0] req_request_pages,
   input  wire logic [OW-1:0] req_page_offset,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [OW-1:0]      rsp_block_offset,
   output logic [PW-1:0]      rsp_block_pages,
   output logic [PW-1:0]      rsp_free_count,
   input  wire logic          csr_we,
   input  wire logic [PW-1:0] csr_managed_pages
);

   bta_cmd_type cmd;
   bta_sts_type sts;

   bta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bta_dpath #(.PAGE_CAP(PAGE_CAP), .PW(PW), .OW(OW)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_request_pages (req_request_pages),
      .req_page_offset   (req_page_offset),
      .csr_we            (csr_we),
      .csr_managed_pages (csr_managed_pages),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_offset  (rsp_block_offset),
      .rsp_block_pages   (rsp_block_pages),
      .rsp_free_count    (rsp_free_count)
   );

endmodule

`default_nettype wire

// ===== hdl/bta_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module bta_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ===== hdl/bta_ctrl.sv =====
// Controller state machine of the buddy tree page allocator.
// Depends on bta_pkg; drives bta_dpath through bta_cmd_type.
`default_nettype none

module bta_ctrl
   import bta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire bta_sts_type sts,
   output bta_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_SWEEP = 4'd2;
   localparam logic [3:0] S_AROOT = 4'd3;
   localparam logic [3:0] S_ADESC = 4'd4;
   localparam logic [3:0] S_ADAT  = 4'd5;
   localparam logic [3:0] S_FDAT  = 4'd6;
   localparam logic [3:0] S_CRD   = 4'd7;
   localparam logic [3:0] S_CDAT  = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_INIT  = 4'd10;

   logic [3:0] state_ff, state_in;

   // Reset starts in the fill sweep, which builds the tree without a response
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.op)
               OP_BUILD: begin
                  if (sts.managed_zero) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = STS_BADREQ;
                     state_in     = S_FIN;
                  end else begin
                     cmd.start_sweep = 1'b1;
                     state_in        = S_SWEEP;
                  end
               end
               OP_ALLOC: begin
                  if (sts.alloc_bad) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = STS_BADREQ;
                     state_in     = S_FIN;
                  end else begin
                     cmd.rd_root = 1'b1;
                     state_in    = S_AROOT;
                  end
               end
               OP_FREE: begin
                  if (sts.free_bad) begin
                     cmd.set_err  = 1'b1;
                     cmd.err_code = STS_BADREQ;
                     state_in     = S_FIN;
                  end else begin
                     cmd.rd_leaf = 1'b1;
                     state_in    = S_FDAT;
                  end
               end
               default: begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = STS_BADREQ;
                  state_in     = S_FIN;
               end
            endcase
         end
         S_INIT: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (sts.sweep_last) state_in = S_FIN;
         end
         S_AROOT: begin
            if (sts.root_short) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = STS_NOSPACE;
               state_in     = S_FIN;
            end else begin
               state_in = S_ADESC;
            end
         end
         S_ADESC: begin
            if (sts.desc_more) begin
               cmd.desc_rd = 1'b1;
               state_in    = S_ADAT;
            end else if (sts.out_range) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = STS_NOSPACE;
               state_in     = S_FIN;
            end else begin
               cmd.alloc_found = 1'b1;
               state_in        = sts.idx_root ? S_FIN : S_CRD;
            end
         end
         S_ADAT: begin
            cmd.desc_take = 1'b1;
            state_in      = S_ADESC;
         end
         S_FDAT: begin
            if (!sts.node_zero) begin
               if (sts.idx_root) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = STS_NOTALLOC;
                  state_in     = S_FIN;
               end else begin
                  cmd.free_up = 1'b1;
               end
            end else begin
               cmd.free_found = 1'b1;
               state_in       = sts.idx_root ? S_FIN : S_CRD;
            end
         end
         S_CRD: begin
            cmd.climb_rd = 1'b1;
            state_in     = S_CDAT;
         end
         S_CDAT: begin
            cmd.climb_wr = 1'b1;
            state_in     = sts.par_root ? S_FIN : S_CRD;
         end
         S_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/bta_dpath.sv =====
// Datapath of the buddy tree page allocator: tree RAM, walk registers, results.
// Depends on bta_pkg and bta_ram; commanded by bta_ctrl.
`default_nettype none

module bta_dpath
   import bta_pkg::*;
#(
   parameter int unsigned PAGE_CAP = BTA_PAGE_CAP,
   parameter int unsigned PW       = $clog2(PAGE_CAP) + 1,
   parameter int unsigned OW       = $clog2(PAGE_CAP)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire bta_cmd_type   cmd,
   output bta_sts_type        sts,
   input  wire logic [1:0]    req_opcode,
   input  wire logic [PW-1:0] req_request_pages,
   input  wire logic [OW-1:0] req_page_offset,
   input  wire logic          csr_we,
   input  wire logic [PW-1:0] csr_managed_pages,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [OW-1:0]      rsp_block_offset,
   output logic [PW-1:0]      rsp_block_pages,
   output logic [PW-1:0]      rsp_free_count
);

   localparam int unsigned DEPTH = 2 * PAGE_CAP - 1;
   localparam int unsigned IW    = $clog2(DEPTH);
   localparam logic [PW-1:0] MAXV = PW'(PAGE_CAP);

   logic [PW-1:0] managed_ff, span_ff, active_ff, free_ff;
   logic [1:0]    op_ff;
   logic [PW-1:0] req_ff, size_ff;
   logic [IW-1:0] idx_ff;
   logic [PW-1:0] nsize_ff, off_ff, val_ff;
   logic [1:0]    res_sts_ff;
   logic [OW-1:0] res_off_ff;
   logic [PW-1:0] res_pages_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_sts_ff;
   logic [OW-1:0] rsp_off_ff;
   logic [PW-1:0] rsp_pages_ff, rsp_free_ff;

   // RAM ports
   logic          we, re;
   logic [IW-1:0] waddr, raddr;
   logic [PW-1:0] wdata, rdata;

   bta_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Tree index arithmetic
   logic [IW-1:0] left_idx, parent_idx, sibling_idx, leaf_idx;
   assign left_idx    = {idx_ff[IW-2:0], 1'b1};
   assign parent_idx  = (idx_ff - IW'(1)) >> 1;
   assign sibling_idx = idx_ff[0] ? idx_ff + IW'(1) : idx_ff - IW'(1);
   assign leaf_idx    = IW'(off_ff) + IW'(span_ff) - IW'(1);

   // Rebuild: saturated page count and its span
   logic [PW-1:0] build_pages, build_span;
   assign build_pages = (managed_ff > MAXV) ? MAXV : managed_ff;
   assign build_span  = PW'(bta_ceil_pow2(32'(build_pages)));

   // Rebuild node value: full, empty, or largest aligned run inside
   logic [PW:0]   sweep_end;
   logic [PW-1:0] sweep_val, sweep_next_off;
   assign sweep_end      = {1'b0, off_ff} + {1'b0, nsize_ff};
   assign sweep_next_off = sweep_end[PW-1:0];
   always_comb begin
      if (sweep_end <= {1'b0, active_ff})  sweep_val = nsize_ff;
      else if (off_ff >= active_ff)        sweep_val = '0;
      else sweep_val = PW'(bta_hibit(32'(active_ff - off_ff)));
   end

   // Climb: parent value from the known child and its sibling
   logic [PW-1:0] psize, climb_max, climb_val;
   logic [PW:0]   climb_sum;
   assign psize     = nsize_ff << 1;
   assign climb_sum = {1'b0, val_ff} + {1'b0, rdata};
   assign climb_max = (val_ff > rdata) ? val_ff : rdata;
   assign climb_val = (op_ff == OP_FREE && climb_sum == {1'b0, psize}) ? psize : climb_max;

   // Free: block start is the page offset with the low bits cleared
   logic [PW-1:0] free_base;
   assign free_base = off_ff & ~(nsize_ff - PW'(1));

   // RAM port selection
   always_comb begin
      re    = 1'b0;
      raddr = '0;
      we    = 1'b0;
      waddr = idx_ff;
      wdata = '0;
      if (cmd.rd_root) re = 1'b1;
      if (cmd.rd_leaf) begin re = 1'b1; raddr = leaf_idx;    end
      if (cmd.desc_rd) begin re = 1'b1; raddr = left_idx;    end
      if (cmd.free_up) begin re = 1'b1; raddr = parent_idx;  end
      if (cmd.climb_rd) begin re = 1'b1; raddr = sibling_idx; end
      if (cmd.sweep_step)  begin we = 1'b1; wdata = sweep_val; end
      if (cmd.alloc_found) we = 1'b1;
      if (cmd.free_found)  begin we = 1'b1; wdata = nsize_ff;  end
      if (cmd.climb_wr) begin we = 1'b1; waddr = parent_idx; wdata = climb_val; end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset)       managed_ff <= MAXV;
      else if (csr_we) managed_ff <= csr_managed_pages;
   end

   // Tree geometry, free total and walk registers
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff   <= MAXV;
         active_ff <= MAXV;
         free_ff   <= MAXV;
         idx_ff    <= '0;
         nsize_ff  <= MAXV;
         off_ff    <= '0;
         val_ff    <= '0;
         op_ff     <= OP_BUILD;
      end else begin
         if (cmd.load_req) begin
            op_ff   <= req_opcode;
            req_ff  <= req_request_pages;
            size_ff <= PW'(bta_ceil_pow2(32'(req_request_pages)));
            off_ff  <= PW'(req_page_offset);
         end
         if (cmd.start_sweep) begin
            span_ff   <= build_span;
            active_ff <= build_pages;
            free_ff   <= build_pages;
            idx_ff    <= '0;
            nsize_ff  <= build_span;
            off_ff    <= '0;
         end
         if (cmd.sweep_step) begin
            idx_ff <= idx_ff + IW'(1);
            if (sweep_next_off == span_ff) begin
               off_ff   <= '0;
               nsize_ff <= nsize_ff >> 1;
            end else begin
               off_ff <= sweep_next_off;
            end
         end
         if (cmd.rd_root) begin
            idx_ff   <= '0;
            nsize_ff <= span_ff;
            off_ff   <= '0;
         end
         if (cmd.rd_leaf) begin
            idx_ff   <= leaf_idx;
            nsize_ff <= PW'(1);
         end
         if (cmd.desc_take) begin
            nsize_ff <= nsize_ff >> 1;
            if (rdata >= size_ff) begin
               idx_ff <= left_idx;
            end else begin
               idx_ff <= left_idx + IW'(1);
               off_ff <= off_ff + (nsize_ff >> 1);
            end
         end
         if (cmd.alloc_found) begin
            val_ff  <= '0;
            free_ff <= free_ff - nsize_ff;
         end
         if (cmd.free_up) begin
            idx_ff   <= parent_idx;
            nsize_ff <= psize;
         end
         if (cmd.free_found) begin
            val_ff  <= nsize_ff;
            free_ff <= free_ff + nsize_ff;
         end
         if (cmd.climb_wr) begin
            idx_ff   <= parent_idx;
            nsize_ff <= psize;
            val_ff   <= climb_val;
         end
      end
   end

   // Result of the current command
   always_ff @(posedge clock) begin
      if (cmd.set_err) begin
         res_sts_ff   <= cmd.err_code;
         res_off_ff   <= '0;
         res_pages_ff <= '0;
      end
      if (cmd.start_sweep) begin
         res_sts_ff   <= STS_OK;
         res_off_ff   <= '0;
         res_pages_ff <= '0;
      end
      if (cmd.alloc_found) begin
         res_sts_ff   <= STS_OK;
         res_off_ff   <= OW'(off_ff);
         res_pages_ff <= nsize_ff;
      end
      if (cmd.free_found) begin
         res_sts_ff   <= STS_OK;
         res_off_ff   <= OW'(free_base);
         res_pages_ff <= nsize_ff;
      end
   end

   // Response output register
   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.emit)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.emit) begin
         rsp_sts_ff   <= res_sts_ff;
         rsp_off_ff   <= res_off_ff;
         rsp_pages_ff <= res_pages_ff;
         rsp_free_ff  <= free_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_sts_ff;
   assign rsp_block_offset = rsp_off_ff;
   assign rsp_block_pages  = rsp_pages_ff;
   assign rsp_free_count   = rsp_free_ff;

   // Status to the controller
   always_comb begin
      sts              = '0;
      sts.op           = op_ff;
      sts.managed_zero = (managed_ff == '0);
      sts.alloc_bad    = (req_ff == '0) || (req_ff > active_ff);
      sts.free_bad     = (off_ff >= active_ff);
      sts.root_short   = (rdata < size_ff);
      sts.desc_more    = (nsize_ff > size_ff);
      sts.out_range    = (off_ff >= active_ff);
      sts.sweep_last   = (nsize_ff == PW'(1)) && (sweep_next_off == span_ff);
      sts.node_zero    = (rdata == '0);
      sts.idx_root     = (idx_ff == '0);
      sts.par_root     = (parent_idx == '0);
      sts.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

endmodule

`default_nettype wire

// ===== hdl/bta_checker.sv =====
// Port-level assertions for the buddy tree page allocator, bound to the top.
// Depends on bta_pkg and buddy_tree_page_allocator.
`default_nettype none

module bta_checker
   import bta_pkg::*;
#(
   parameter int unsigned PAGE_CAP = BTA_PAGE_CAP,
   parameter int unsigned PW       = $clog2(PAGE_CAP) + 1,
   parameter int unsigned OW       = $clog2(PAGE_CAP)
) (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire logic [1:0]    rsp_status,
   input wire logic [OW-1:0] rsp_block_offset,
   input wire logic [PW-1:0] rsp_block_pages,
   input wire logic [PW-1:0] rsp_free_count
);

   // Stalled response holds valid, status, offset and free count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_block_offset) && $stable(rsp_free_count))
      else $error("response changed while stalled");

   // Errors report no block
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_block_pages == '0
         && rsp_block_offset == '0)
      else $error("error response carries a block");

   // A reported block is a power of two, aligned to its size
   a_blk_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_block_pages != '0 |-> $onehot(rsp_block_pages)
         && ((PW'(rsp_block_offset) & (rsp_block_pages - PW'(1))) == '0))
      else $error("block not aligned power of two");

   // Free count never exceeds the tree capacity
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_count <= PW'(PAGE_CAP))
      else $error("free count out of range");

endmodule

bind buddy_tree_page_allocator bta_checker #(
   .PAGE_CAP(PAGE_CAP), .PW(PW), .OW(OW)
) u_bta_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_block_offset (rsp_block_offset),
   .rsp_block_pages  (rsp_block_pages),
   .rsp_free_count   (rsp_free_count)
);

`default_nettype wire
